@@ sv/pce_pkg.sv @@
`default_nettype none
package pce_pkg;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_DATA   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_ABORT  = 2'd3;

  localparam logic [1:0] WSEL_7  = 2'd0;
  localparam logic [1:0] WSEL_8  = 2'd1;
  localparam logic [1:0] WSEL_16 = 2'd2;
  localparam logic [1:0] WSEL_32 = 2'd3;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_SEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLYNOMIAL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_XOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REFLECT_IN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REFLECT_OUT = 3'd5;

  localparam logic [31:0] RST_POLY  = 32'h04C1_1DB7;
  localparam logic [31:0] RST_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] RST_FXOR  = 32'hFFFF_FFFF;
  localparam logic [31:0] MASK_7    = 32'h0000_007F;
  localparam logic [31:0] MASK_8    = 32'h0000_00FF;
  localparam logic [31:0] MASK_16   = 32'h0000_FFFF;
  localparam logic [31:0] MASK_32   = 32'hFFFF_FFFF;
  localparam logic [31:0] BYTES_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  wsel;
    logic [31:0] poly;
    logic [31:0] init;
    logic [31:0] fxor;
    logic        rin;
    logic        rout;
  } pce_cfg_t;

  typedef struct packed {
    logic        load;    // preset register to init value
    logic        start;   // begin feeding word
    logic [31:0] word;
    logic [2:0]  nbytes;  // 1..4
  } pce_core_ctrl_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] crc;
  } pce_core_stat_t;

  function automatic logic [31:0] width_mask(input logic [1:0] wsel);
    logic [31:0] m;
    case (wsel)
      WSEL_7:  m = MASK_7;
      WSEL_8:  m = MASK_8;
      WSEL_16: m = MASK_16;
      default: m = MASK_32;
    endcase
    return m;
  endfunction

  function automatic logic top_bit(input logic [31:0] v, input logic [1:0] wsel);
    logic b;
    case (wsel)
      WSEL_7:  b = v[6];
      WSEL_8:  b = v[7];
      WSEL_16: b = v[15];
      default: b = v[31];
    endcase
    return b;
  endfunction

  // one byte through the shift/xor register, eight bit steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data,
                                           input pce_cfg_t    cfg);
    logic [31:0] m;
    logic [31:0] p;
    logic [31:0] c;
    logic        bit_in;
    logic        fb;
    m = width_mask(cfg.wsel);
    p = cfg.poly & m;
    c = crc_in & m;
    for (int i = 0; i < 8; i++) begin
      bit_in = cfg.rin ? data[i] : data[7-i];
      fb     = top_bit(c, cfg.wsel) ^ bit_in;
      c      = (c << 1) & m;
      if (fb) c = c ^ p;
    end
    return c;
  endfunction

  function automatic logic [31:0] reverse_width(input logic [31:0] v,
                                                input logic [1:0]  wsel);
    logic [31:0] r;
    logic [31:0] o;
    for (int i = 0; i < 32; i++) r[i] = v[31-i];
    case (wsel)
      WSEL_7:  o = r >> 25;
      WSEL_8:  o = r >> 24;
      WSEL_16: o = r >> 16;
      default: o = r;
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

@@ sv/pce_ifs.sv @@
`default_nettype none
interface pce_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] data_word;
  logic [2:0]  byte_count_in;
  modport source (output valid, output op, output data_word, output byte_count_in,
                  input ready);
  modport sink   (input valid, input op, input data_word, input byte_count_in,
                  output ready);
endinterface

interface pce_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        active;
  logic        crc_done;
  logic [31:0] crc_result;
  logic [31:0] total_bytes;
  modport source (output valid, output status, output active, output crc_done,
                  output crc_result, output total_bytes, input ready);
  modport sink   (input valid, input status, input active, input crc_done,
                  input crc_result, input total_bytes, output ready);
endinterface

interface pce_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ sv/parametric_crc_engine_unit.sv @@
// Parametric CRC engine, bus-fed peripheral.
// Channels: in_ch carries one command beat (op, data_word, byte_count_in);
// out_ch returns exactly one response beat per command (status, active,
// crc_done, crc_result, total_bytes); cfg_ch writes one register per
// beat, index 0..5 = width_select, polynomial, init_value, final_xor,
// reflect_in, reflect_out. cfg_ch is always ready; write only while idle.
// Sequencing: a data command feeds one byte per cycle through the core's
// byte shift line; once its bytes are shifted, the response register loads.
// Start, finish, abort, a refused command and a zero-byte data command skip
// the byte feed and go straight to the response state. in_ch.ready returns
// once the response register has loaded.
// One command is in flight at a time; in_ch.ready is high only when idle.
// Stall: the response waits in an output register; the engine is free to
// take the next command, and only holds its response when the output
// register is still full.
// Reset (rst_n, synchronous, active low) restores the default CRC-32
// configuration, clears the engine state and drops out_ch.valid.
`default_nettype none
module parametric_crc_engine_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pce_in_if.sink     in_ch,
  pce_out_if.source  out_ch,
  pce_cfg_if.sink    cfg_ch
);
  import pce_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FEED = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state_r, state_nxt;

  // configuration registers
  pce_cfg_t cfg_r;

  // engine state
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] final_r, final_nxt;
  logic [31:0] fed_r, fed_nxt;
  logic        stat_r, stat_nxt;

  // response register
  logic        ovalid_r;
  logic        o_status_r, o_active_r, o_rvalid_r;
  logic [31:0] o_crc_r, o_total_r;

  pce_core_ctrl_t core_ctrl;
  pce_core_stat_t core_stat;

  logic        in_fire;
  logic        o_load;
  logic [2:0]  nbytes;
  logic [32:0] fed_sum;
  logic [31:0] fin_v;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wsel <= WSEL_32;
      cfg_r.poly <= RST_POLY;
      cfg_r.init <= RST_INIT;
      cfg_r.fxor <= RST_FXOR;
      cfg_r.rin  <= 1'b1;
      cfg_r.rout <= 1'b1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_WIDTH_SEL:   cfg_r.wsel <= cfg_ch.data[1:0];
        REG_POLYNOMIAL:  cfg_r.poly <= cfg_ch.data;
        REG_INIT_VALUE:  cfg_r.init <= cfg_ch.data;
        REG_FINAL_XOR:   cfg_r.fxor <= cfg_ch.data;
        REG_REFLECT_IN:  cfg_r.rin  <= cfg_ch.data[0];
        REG_REFLECT_OUT: cfg_r.rout <= cfg_ch.data[0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // byte count: 5..7 clamp to four
  always_comb begin
    nbytes = (in_ch.byte_count_in > 3'd4) ? 3'd4 : in_ch.byte_count_in;
  end

  assign fed_sum = {1'b0, fed_r} + {30'd0, nbytes};
  assign fin_v   = cfg_r.rout
                 ? reverse_width(core_stat.crc & width_mask(cfg_r.wsel), cfg_r.wsel)
                 : (core_stat.crc & width_mask(cfg_r.wsel));

  always_comb begin
    state_nxt       = state_r;
    busy_nxt        = busy_r;
    done_nxt        = done_r;
    final_nxt       = final_r;
    fed_nxt         = fed_r;
    stat_nxt        = stat_r;
    core_ctrl.load  = 1'b0;
    core_ctrl.start = 1'b0;
    core_ctrl.word  = in_ch.data_word;
    core_ctrl.nbytes = nbytes;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_RESP;
          stat_nxt  = 1'b0;
          if (in_ch.op == OP_START) begin
            if (busy_r) begin
              stat_nxt = 1'b1;
            end else begin
              core_ctrl.load = 1'b1;
              busy_nxt  = 1'b1;
              done_nxt  = 1'b0;
              final_nxt = '0;
              fed_nxt   = '0;
            end
          end else if (!busy_r) begin
            stat_nxt = 1'b1;
          end else if (in_ch.op == OP_DATA) begin
            fed_nxt = fed_sum[32] ? BYTES_MAX : fed_sum[31:0];
            if (nbytes != 3'd0) begin
              core_ctrl.start = 1'b1;
              state_nxt       = ST_FEED;
            end
          end else if (in_ch.op == OP_FINISH) begin
            final_nxt = (fin_v ^ cfg_r.fxor) & width_mask(cfg_r.wsel);
            done_nxt  = 1'b1;
            busy_nxt  = 1'b0;
          end else begin
            busy_nxt = 1'b0;  // abort keeps the byte count
          end
        end
      end
      ST_FEED: begin
        if (!core_stat.busy) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (o_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign o_load = (state_r == ST_RESP) && (!ovalid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
      final_r  <= '0;
      fed_r    <= '0;
      stat_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      final_r <= final_nxt;
      fed_r   <= fed_nxt;
      stat_r  <= stat_nxt;
      if (o_load)            ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_status_r <= stat_r;
      o_active_r <= busy_r;
      o_rvalid_r <= done_r;
      o_crc_r    <= done_r ? final_r : 32'd0;
      o_total_r  <= fed_r;
    end
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.status       = o_status_r;
  assign out_ch.active       = o_active_r;
  assign out_ch.crc_done     = o_rvalid_r;
  assign out_ch.crc_result   = o_crc_r;
  assign out_ch.total_bytes  = o_total_r;

  pce_crc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .ctrl  (core_ctrl),
    .stat  (core_stat)
  );

endmodule
`default_nettype wire

@@ sv/pce_crc_core.sv @@
`default_nettype none
module pce_crc_core (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire pce_pkg::pce_cfg_t       cfg,
  input  wire pce_pkg::pce_core_ctrl_t ctrl,
  output pce_pkg::pce_core_stat_t      stat
);
  import pce_pkg::*;

  logic [31:0] crc_r, crc_nxt;
  logic [31:0] sh_r, sh_nxt;    // byte shift line, low byte goes next
  logic [2:0]  left_r, left_nxt;

  always_comb begin
    crc_nxt  = crc_r;
    sh_nxt   = sh_r;
    left_nxt = left_r;
    if (ctrl.load) begin
      crc_nxt = cfg.init & width_mask(cfg.wsel);
    end else if (ctrl.start) begin
      sh_nxt   = ctrl.word;
      left_nxt = ctrl.nbytes;
    end else if (left_r != 3'd0) begin
      crc_nxt  = crc_byte(crc_r, sh_r[7:0], cfg);
      sh_nxt   = {8'h00, sh_r[31:8]};
      left_nxt = left_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= '0;
      left_r <= '0;
    end else begin
      crc_r  <= crc_nxt;
      left_r <= left_nxt;
    end
    sh_r <= sh_nxt;
  end

  assign stat.busy = (left_r != 3'd0);
  assign stat.crc  = crc_r;

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none
import pce_pkg::*;

// One response beat as the engine reports it.
typedef struct packed {
  logic        status;
  logic        active;
  logic        crc_done;
  logic [31:0] crc_result;
  logic [31:0] total_bytes;
} crc_resp_t;

// Tracks the engine's CRC state and the response each command beat should draw.
class crc_scoreboard;
  logic [1:0]  wsel;
  logic [31:0] poly;
  logic [31:0] init_val;
  logic [31:0] fxor;
  logic        rin;
  logic        rout;

  logic [31:0] crc_q;
  logic        engaged;
  logic        latched;
  logic [31:0] latched_crc;
  logic [31:0] fed;

  crc_resp_t   resp_q[$];
  int          mismatches;

  function new();
    wsel        = WSEL_32;
    poly        = RST_POLY;
    init_val    = RST_INIT;
    fxor        = RST_FXOR;
    rin         = 1'b1;
    rout        = 1'b1;
    crc_q       = '0;
    engaged     = 1'b0;
    latched     = 1'b0;
    latched_crc = '0;
    fed         = '0;
    mismatches  = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_WIDTH_SEL:   wsel     = v[1:0];
      REG_POLYNOMIAL:  poly     = v;
      REG_INIT_VALUE:  init_val = v;
      REG_FINAL_XOR:   fxor     = v;
      REG_REFLECT_IN:  rin      = v[0];
      REG_REFLECT_OUT: rout     = v[0];
      default: ;
    endcase
  endfunction

  function int unsigned nbits();
    case (wsel)
      WSEL_7:  return 7;
      WSEL_8:  return 8;
      WSEL_16: return 16;
      default: return 32;
    endcase
  endfunction

  function logic [31:0] wmask();
    int unsigned n;
    n = nbits();
    return (n == 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
  endfunction

  function logic [31:0] shift_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0]  m;
    int unsigned  n;
    logic         din;
    logic         fb;
    m = wmask();
    n = nbits();
    c = c & m;
    for (int i = 0; i < 8; i++) begin
      din = rin ? b[i] : b[7-i];
      fb  = c[n-1] ^ din;
      c   = (c << 1) & m;
      if (fb) c = c ^ (poly & m);
    end
    return c;
  endfunction

  function logic [31:0] mirror(logic [31:0] v);
    logic [31:0] r;
    int unsigned n;
    n = nbits();
    r = '0;
    for (int i = 0; i < n; i++)
      if (v[i]) r[n-1-i] = 1'b1;
    return r;
  endfunction

  function void note_command(logic [1:0] op, logic [31:0] word, logic [2:0] cnt);
    crc_resp_t   r;
    logic [31:0] m;
    logic [31:0] v;
    int unsigned n;
    logic        st;
    m  = wmask();
    st = 1'b0;
    if (op == OP_START) begin
      if (engaged) begin
        st = 1'b1;
      end else begin
        crc_q       = init_val & m;
        engaged     = 1'b1;
        latched     = 1'b0;
        latched_crc = '0;
        fed         = '0;
      end
    end else if (!engaged) begin
      st = 1'b1;
    end else if (op == OP_DATA) begin
      n = (cnt > 3'd4) ? 4 : cnt;
      for (int i = 0; i < n; i++)
        crc_q = shift_byte(crc_q, word[8*i +: 8]);
      if (fed > BYTES_MAX - n) fed = BYTES_MAX;
      else fed = fed + n;
    end else if (op == OP_FINISH) begin
      v = crc_q & m;
      if (rout) v = mirror(v);
      latched_crc = (v ^ fxor) & m;
      latched     = 1'b1;
      engaged     = 1'b0;
    end else begin
      engaged = 1'b0;
    end
    r.status       = st;
    r.active       = engaged;
    r.crc_done     = latched;
    r.crc_result   = latched ? latched_crc : 32'h0;
    r.total_bytes  = fed;
    resp_q.push_back(r);
  endfunction

  function void check_response(crc_resp_t got);
    crc_resp_t want;
    if (resp_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected response beat: st=%0d act=%0d done=%0d crc=%08h bytes=%0d",
                 got.status, got.active, got.crc_done, got.crc_result,
                 got.total_bytes);
      return;
    end
    want = resp_q.pop_front();
    if (got.status !== want.status || got.active !== want.active ||
        got.crc_done !== want.crc_done ||
        got.crc_result !== want.crc_result || got.total_bytes !== want.total_bytes) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch exp: st=%0d act=%0d done=%0d crc=%08h bytes=%0d",
                 want.status, want.active, want.crc_done, want.crc_result,
                 want.total_bytes);
        $display("         got: st=%0d act=%0d done=%0d crc=%08h bytes=%0d",
                 got.status, got.active, got.crc_done, got.crc_result,
                 got.total_bytes);
      end
    end
  endfunction

  function int pending();
    return resp_q.size();
  endfunction
endclass

module tb;
  // indexes past the last register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic clk;
  logic rst_n;

  pce_in_if  in_ch();
  pce_out_if out_ch();
  pce_cfg_if cfg_ch();

  parametric_crc_engine_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  crc_scoreboard sb = new();

  int  sent_items = 0;
  bit  tx_burst   = 0;   // sender offers back to back
  bit  rx_burst   = 0;   // receiver never drops ready
  bit  stall_req  = 0;   // ask the receiver for one long hold-off
  int  hold_left  = 0;
  int  gap_left   = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Generous cap: slowest legal run is well under a quarter of this.
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    else if (r < 90) return $urandom_range(3, 8);
    else return $urandom_range(20, 60);
  endfunction

  // Receiver: check the beat taken at this edge, then pick next ready.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_response('{out_ch.status, out_ch.active, out_ch.crc_done,
                          out_ch.crc_result, out_ch.total_bytes});
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_req) begin
      // long back-pressure: output register fills, engine must stall in_ch
      stall_req = 0;
      hold_left = 300;
      out_ch.ready <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!rx_burst && $urandom_range(0, 99) < 30) gap_left = pick_gap();
    end
  end

  // One command beat. valid stays up on return so back-to-back beats
  // never see valid lowered and raised in the same step.
  task automatic send_cmd(input logic [1:0] op, input logic [31:0] word,
                          input logic [2:0] cnt);
    int gap;
    gap = (tx_burst || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.data_word     <= word;
    in_ch.byte_count_in <= cnt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_command(op, word, cnt);
    sent_items++;
  endtask

  // One register write beat; valid likewise left up for the next one.
  task automatic write_cfg(input logic [2:0] idx, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  // Let every outstanding response drain, plus the engine's latency.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write all six registers; junk above the field or the width must be ignored.
  task automatic apply_setting(input logic [1:0] w, input logic [31:0] p,
                               input logic [31:0] iv, input logic [31:0] fx,
                               input logic ri, input logic ro);
    logic [31:0] m;
    case (w)
      WSEL_7:  m = MASK_7;
      WSEL_8:  m = MASK_8;
      WSEL_16: m = MASK_16;
      default: m = MASK_32;
    endcase
    write_cfg(REG_WIDTH_SEL,   ($urandom & 32'hFFFF_FFFC) | w);
    write_cfg(REG_POLYNOMIAL,  p  | ($urandom & ~m));
    write_cfg(REG_INIT_VALUE,  iv | ($urandom & ~m));
    write_cfg(REG_FINAL_XOR,   fx | ($urandom & ~m));
    write_cfg(REG_REFLECT_IN,  ($urandom & 32'hFFFF_FFFE) | ri);
    write_cfg(REG_REFLECT_OUT, ($urandom & 32'hFFFF_FFFE) | ro);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed start/data/finish sessions, some aborted or left
  // open, plus stray commands in any state.
  task automatic run_random(input int n_items);
    int          goal;
    int          r;
    int          k;
    logic [2:0]  cnt;
    goal = sent_items + n_items;
    while (sent_items < goal) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        send_cmd(OP_START, $urandom, 3'($urandom));
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
        repeat (k) begin
          cnt = ($urandom_range(0, 9) < 7) ? 3'(1 << $urandom_range(0, 2))
                                           : 3'($urandom);
          send_cmd(OP_DATA, $urandom, cnt);
        end
        r = $urandom_range(0, 99);
        if (r < 80) send_cmd(OP_FINISH, $urandom, 3'($urandom));
        else if (r < 95) send_cmd(OP_ABORT, $urandom, 3'($urandom));
        // else: session left open, next start is refused
      end else begin
        send_cmd(2'($urandom), $urandom, 3'($urandom));
      end
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.op            = OP_START;
    in_ch.data_word     = '0;
    in_ch.byte_count_in = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_WIDTH_SEL;
    cfg_ch.data         = '0;
    out_ch.ready        = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset CRC-32 setting, wrong-state commands, check string,
    // odd byte counts, extreme data words.
    send_cmd(OP_DATA,   32'h1234_5678, 3'd4);   // not active: refused
    send_cmd(OP_FINISH, 32'h0, 3'd0);
    send_cmd(OP_ABORT,  32'h0, 3'd0);
    send_cmd(OP_START,  32'h0, 3'd0);
    send_cmd(OP_START,  32'hFFFF_FFFF, 3'd7);   // already active: refused
    send_cmd(OP_DATA,   32'h3433_3231, 3'd4);   // "123456789"
    send_cmd(OP_DATA,   32'h3837_3635, 3'd4);
    send_cmd(OP_DATA,   32'h0000_0039, 3'd1);
    send_cmd(OP_FINISH, 32'h0, 3'd0);
    send_cmd(OP_DATA,   32'hFFFF_FFFF, 3'd4);   // after finish: refused
    send_cmd(OP_START,  32'h0, 3'd0);
    send_cmd(OP_DATA,   32'hDEAD_BEEF, 3'd0);   // zero bytes, still accepted
    send_cmd(OP_DATA,   32'hA5C3_0F96, 3'd3);
    send_cmd(OP_DATA,   32'h0123_4567, 3'd5);   // clipped to four
    send_cmd(OP_DATA,   32'h89AB_CDEF, 3'd6);
    send_cmd(OP_DATA,   32'hFFFF_FFFF, 3'd7);
    send_cmd(OP_DATA,   32'h0000_0000, 3'd2);
    send_cmd(OP_FINISH, 32'hFFFF_FFFF, 3'd7);
    send_cmd(OP_START,  32'h0, 3'd0);
    send_cmd(OP_DATA,   32'h5555_AAAA, 3'd4);
    send_cmd(OP_ABORT,  32'h0, 3'd0);           // byte count stays visible
    send_cmd(OP_FINISH, 32'h0, 3'd0);           // refused after abort
    send_cmd(OP_START,  32'h0, 3'd0);
    send_cmd(OP_FINISH, 32'h0, 3'd0);           // empty message

    // Random phases, each under its own setting; the engine may still be
    // active from an open session when the registers change.
    for (int p = 0; p < 13; p++) begin
      drain();
      tx_burst = (p % 4 == 1) || (p == 3);
      rx_burst = (p % 4 == 2);
      case (p)
        0:  apply_setting(WSEL_7,  32'h09, 32'h00, 32'h00, 1'b0, 1'b0);
        1:  apply_setting(WSEL_8,  32'h07, 32'h00, 32'h00, 1'b0, 1'b0);
        2:  apply_setting(WSEL_16, 32'h1021, 32'hFFFF, 32'h0, 1'b0, 1'b0);
        3:  apply_setting(WSEL_16, 32'h8005, 32'h0, 32'h0, 1'b1, 1'b1);
        4:  apply_setting(WSEL_32, RST_POLY, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
        5:  apply_setting(WSEL_32, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1);
        6:  apply_setting(WSEL_7,  32'h0, 32'h7F, 32'h7F, 1'b1, 1'b0);
        12: apply_setting(WSEL_32, RST_POLY, RST_INIT, RST_FXOR, 1'b1, 1'b1);
        default: apply_setting(2'($urandom), $urandom, $urandom, $urandom,
                               1'($urandom), 1'($urandom));
      endcase
      if (p == 6) begin
        write_cfg(REG_SPARE_6, $urandom);
        write_cfg(REG_SPARE_7, $urandom);
        cfg_ch.valid <= 1'b0;
      end
      if (p == 3) stall_req = 1;
      run_random(60);
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
